FILE: rtl/core/drd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_pkg: shared types and constants of the divide/remainder pipeline
// Operation codes, word width and the record that moves from cell to cell.
// ----------------------------------------------------------------------------
package drd_pkg;

    localparam int XLEN = 64;

    localparam logic [1:0] OP_DIV  = 2'd0;
    localparam logic [1:0] OP_DIVU = 2'd1;
    localparam logic [1:0] OP_REM  = 2'd2;
    localparam logic [1:0] OP_REMU = 2'd3;

    // one in-flight division
    typedef struct packed {
        logic            rem_sel;  // deliver remainder instead of quotient
        logic            neg;      // negate the selected magnitude at the end
        logic [XLEN-1:0] part;     // partial remainder
        logic [XLEN-1:0] quo;      // dividend bits shifting out, quotient bits in
        logic [XLEN-1:0] dvs;      // divisor magnitude
    } stage_t;

endpackage

FILE: rtl/core/drd_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_prep: operand preparation stage
// Decodes the operation, takes operand magnitudes and works out the final sign.
// ----------------------------------------------------------------------------
module drd_prep (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_operation,
    input  logic [drd_pkg::XLEN-1:0]   in_dividend,
    input  logic [drd_pkg::XLEN-1:0]   in_divisor,
    output logic                       out_valid,
    input  logic                       out_ready,
    output drd_pkg::stage_t            out_stage
);

    logic            valid_reg;
    drd_pkg::stage_t stage_reg;
    drd_pkg::stage_t stage_next;

    logic is_signed;
    logic want_rem;
    logic neg_a;
    logic neg_b;
    logic div_zero;

    always_comb begin
        is_signed = (in_operation == drd_pkg::OP_DIV) || (in_operation == drd_pkg::OP_REM);
        want_rem  = (in_operation == drd_pkg::OP_REM) || (in_operation == drd_pkg::OP_REMU);
        neg_a     = is_signed && in_dividend[drd_pkg::XLEN-1];
        neg_b     = is_signed && in_divisor[drd_pkg::XLEN-1];
        div_zero  = (in_divisor == '0);

        stage_next.rem_sel = want_rem;
        // divide by zero yields all ones from the array, so keep it positive
        stage_next.neg     = want_rem ? neg_a : ((neg_a ^ neg_b) && !div_zero);
        stage_next.part    = '0;
        stage_next.quo     = neg_a ? (-in_dividend) : in_dividend;
        stage_next.dvs     = neg_b ? (-in_divisor) : in_divisor;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            stage_reg <= stage_next;
        end
    end

endmodule

FILE: rtl/core/drd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_cell: one restoring division step
// Shifts one dividend bit into the partial remainder and trial-subtracts.
// ----------------------------------------------------------------------------
module drd_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  drd_pkg::stage_t in_stage,
    output logic            out_valid,
    input  logic            out_ready,
    output drd_pkg::stage_t out_stage
);

    logic            valid_reg;
    drd_pkg::stage_t stage_reg;
    drd_pkg::stage_t stage_next;

    logic [drd_pkg::XLEN:0] trial;
    logic [drd_pkg::XLEN:0] diff;
    logic                   take;

    always_comb begin
        trial = {in_stage.part, in_stage.quo[drd_pkg::XLEN-1]};
        diff  = trial - {1'b0, in_stage.dvs};
        take  = !diff[drd_pkg::XLEN];

        stage_next      = in_stage;
        // partial remainder stays below the divisor, so the difference fits
        stage_next.part = take ? diff[drd_pkg::XLEN-1:0] : trial[drd_pkg::XLEN-1:0];
        stage_next.quo  = {in_stage.quo[drd_pkg::XLEN-2:0], take};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            stage_reg <= stage_next;
        end
    end

endmodule

FILE: rtl/core/drd_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_post: result selection and output register
// Picks quotient or remainder, applies the sign and holds the result.
// ----------------------------------------------------------------------------
module drd_post (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  drd_pkg::stage_t          in_stage,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [drd_pkg::XLEN-1:0] out_result
);

    logic                     valid_reg;
    logic [drd_pkg::XLEN-1:0] result_reg;
    logic [drd_pkg::XLEN-1:0] result_next;
    logic [drd_pkg::XLEN-1:0] mag;

    always_comb begin
        mag         = in_stage.rem_sel ? in_stage.part : in_stage.quo;
        result_next = in_stage.neg ? (-mag) : mag;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/core/riscv_divide_remainder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_divide_remainder: pipelined 64-bit DIV/DIVU/REM/REMU unit
// Operand prep stage, a chain of 64 division cells and an output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries s_operation, s_dividend and s_divisor under s_valid and
//   s_ready; m_ channel returns m_result under m_valid and m_ready. An item
//   moves on every cycle in which valid and ready are both high.
//   An item passes through 66 register stages, the last of which drives m_valid. The
//   stages are one for operand magnitudes, one for each of the 64 restoring
//   division cells (one quotient bit each) and one for sign fix in the
//   output register.
//   Throughput is one item per cycle while m_ready stays high; every stage
//   holds its own item, so up to 66 divisions are in flight at once.
//   When the receiver stalls, the output register holds its result and items
//   keep advancing into empty stages behind it; s_ready falls only once every
//   stage from the input up to the output is full.
//   Reset clears every stage valid bit; the pipeline comes up empty and
//   s_ready is high right after reset.
//   Divide by zero and the signed overflow case follow RISC-V rules.
// ----------------------------------------------------------------------------
module riscv_divide_remainder (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic [drd_pkg::XLEN-1:0] s_dividend,
    input  logic [drd_pkg::XLEN-1:0] s_divisor,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [drd_pkg::XLEN-1:0] m_result
);

    localparam int NCELL = drd_pkg::XLEN;

    // chain index 0 is the prep output, index NCELL the last cell output
    logic            chain_valid [NCELL+1];
    logic            chain_ready [NCELL+1];
    drd_pkg::stage_t chain_stage [NCELL+1];

    drd_prep u_prep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_operation (s_operation),
        .in_dividend  (s_dividend),
        .in_divisor   (s_divisor),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_stage    (chain_stage[0])
    );

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        drd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_stage  (chain_stage[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_stage (chain_stage[i+1])
        );
    end

    drd_post u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (chain_valid[NCELL]),
        .in_ready   (chain_ready[NCELL]),
        .in_stage   (chain_stage[NCELL]),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (m_result)
    );

    // an empty output register makes the whole chain ready
    a_empty_out_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // the last cell can only be held back by a full output register
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain_valid[NCELL] && !chain_ready[NCELL]) |-> (m_valid && !m_ready))
        else $error("last cell stalled without output backpressure");

    // restoring division keeps the partial remainder below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain_valid[NCELL] && (chain_stage[NCELL].dvs != '0))
            |-> (chain_stage[NCELL].part < chain_stage[NCELL].dvs))
        else $error("final remainder not below divisor");

endmodule
